@@ sv/lobm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, codes and defaults of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int MAX_ORDERS_DEF = 64;

  // event commands; codes five to seven are ignored
  localparam logic [2:0] CMD_ADD_LIMIT  = 3'd0;
  localparam logic [2:0] CMD_ADD_MARKET = 3'd1;
  localparam logic [2:0] CMD_CANCEL     = 3'd2;
  localparam logic [2:0] CMD_MODIFY     = 3'd3;
  localparam logic [2:0] CMD_REDUCE     = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [15:0] symbol;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] ord_ref;
    logic [31:0] arrival;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_FILL,
    ST_RESCAN,
    ST_INSERT,
    ST_FINAL
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_FILL,
    OP_INSERT,
    OP_TARGET,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic free_found;
    logic tgt_found;
    logic pend_vld;
    logic out_free;
    logic cont;
    logic scan_needed;
    logic is_add;
    logic limited;
    logic rem_zero;
  } dp_sts_t;

endpackage

@@ sv/lobm_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_req_if
// Event channel: one word per order book event.
// ----------------------------------------------------------------------------
interface lobm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] symbol_code;
  logic [31:0] ord_ref;
  logic        side;
  logic [31:0] price;
  logic [31:0] quantity;
  logic [62:0] timestamp;

  modport source (output valid, cmd, symbol_code, ord_ref, side, price, quantity,
                  timestamp, input ready);
  modport sink (input valid, cmd, symbol_code, ord_ref, side, price, quantity,
                timestamp, output ready);
endinterface

@@ sv/lobm_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_rsp_if
// Result channel: one word per trade, or one status word per event.
// ----------------------------------------------------------------------------
interface lobm_rsp_if;
  logic        valid;
  logic        ready;
  logic        has_trade;
  logic [62:0] trade_time;
  logic [31:0] resting_ref;
  logic [31:0] taker_ref;
  logic [15:0] trade_symbol;
  logic [31:0] trade_price;
  logic [31:0] trade_quantity;
  logic        taker_side;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, has_trade, trade_time, resting_ref,
                  taker_ref, trade_symbol, trade_price, trade_quantity,
                  taker_side, status, last, input ready);
  modport sink (input valid, has_trade, trade_time, resting_ref,
                taker_ref, trade_symbol, trade_price, trade_quantity,
                taker_side, status, last, output ready);
endinterface

@@ sv/lobm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ctrl
// Event sequencer: scans, fills, inserts and result ordering.
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lobm_pkg::dp_sts_t sts,
  output lobm_pkg::dp_cmd_t dcmd
);

  lobm_pkg::state_t state, state_next;
  logic [1:0] st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lobm_pkg::ST_IDLE;
      st    <= lobm_pkg::ST_DONE;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next  = state;
    st_next     = st;
    dcmd.op     = lobm_pkg::OP_NONE;
    dcmd.status = st;
    req_ready   = 1'b0;
    unique case (state)
      lobm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          dcmd.op    = lobm_pkg::OP_LOAD;
          st_next    = lobm_pkg::ST_DONE;
          state_next = lobm_pkg::ST_DISPATCH;
        end
      end
      lobm_pkg::ST_DISPATCH: begin
        if (sts.scan_needed) begin
          dcmd.op    = lobm_pkg::OP_SCAN;
          state_next = lobm_pkg::ST_SCAN;
        end else begin
          state_next = lobm_pkg::ST_FINAL;
        end
      end
      lobm_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = lobm_pkg::ST_DECIDE;
      end
      lobm_pkg::ST_DECIDE: begin
        if (sts.is_add) begin
          priority if (sts.best_found) begin
            state_next = lobm_pkg::ST_FILL;
          end else if (sts.limited && !sts.rem_zero) begin
            if (sts.free_found) begin
              state_next = lobm_pkg::ST_INSERT;
            end else begin
              st_next    = lobm_pkg::ST_FULL;
              state_next = lobm_pkg::ST_FINAL;
            end
          end else begin
            state_next = lobm_pkg::ST_FINAL;
          end
        end else begin
          if (sts.tgt_found) dcmd.op = lobm_pkg::OP_TARGET;
          else st_next = lobm_pkg::ST_NOT_FOUND;
          state_next = lobm_pkg::ST_FINAL;
        end
      end
      lobm_pkg::ST_FILL: begin
        // an earlier trade still waiting must go out first
        if (!sts.pend_vld || sts.out_free) begin
          dcmd.op    = lobm_pkg::OP_FILL;
          state_next = sts.cont ? lobm_pkg::ST_RESCAN : lobm_pkg::ST_FINAL;
        end
      end
      lobm_pkg::ST_RESCAN: begin
        dcmd.op    = lobm_pkg::OP_SCAN;
        state_next = lobm_pkg::ST_SCAN;
      end
      lobm_pkg::ST_INSERT: begin
        dcmd.op    = lobm_pkg::OP_INSERT;
        state_next = lobm_pkg::ST_FINAL;
      end
      lobm_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          dcmd.op    = lobm_pkg::OP_FINAL;
          state_next = lobm_pkg::ST_IDLE;
        end
      end
      default: state_next = lobm_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ sv/lobm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_dp
// Slot memory, scan compare, fill arithmetic and result register.
// ----------------------------------------------------------------------------
module lobm_dp #(
  parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lobm_req_if.sink          req,
  lobm_rsp_if.source        rsp,
  input  lobm_pkg::dp_cmd_t dcmd,
  output lobm_pkg::dp_sts_t sts
);

  localparam int IDX_W = $clog2(MAX_ORDERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

  // event word
  logic [2:0]  ev_cmd;
  logic [15:0] ev_sym;
  logic [31:0] ev_id;
  logic        ev_side;
  logic [31:0] ev_price;
  logic [31:0] ev_qty;
  logic [31:0] rem;
  logic [62:0] ev_ts;

  lobm_pkg::slot_t mem [MAX_ORDERS];
  lobm_pkg::slot_t rd_data;
  logic [MAX_ORDERS-1:0] slot_valid;
  logic [31:0] arrival_counter;

  logic             scan_run, rd_pend;
  logic [IDX_W-1:0] scan_idx, rd_idx;

  logic best_found, t0_found, t1_found, free_found;
  logic [IDX_W-1:0] best_idx, t0_idx, t1_idx, free_idx;
  lobm_pkg::slot_t best_e, t0_e, t1_e;

  logic        pend_vld;
  logic [31:0] pend_rid, pend_price, pend_fill;

  logic        out_vld;
  logic        o_trade, o_side, o_last;
  logic [62:0] o_time;
  logic [31:0] o_rid, o_aid, o_price, o_qty;
  logic [15:0] o_sym;
  logic [1:0]  o_status;

  logic is_add, limited, is_tgt, out_free;
  logic [31:0] fill;
  logic cont;
  logic [IDX_W-1:0] t_idx;
  lobm_pkg::slot_t t_e;

  logic we;
  logic [IDX_W-1:0] waddr;
  lobm_pkg::slot_t wdata;

  lobm_pkg::slot_t e;
  logic v, hit_best, better, hit_tgt;

  assign is_add  = (ev_cmd == lobm_pkg::CMD_ADD_LIMIT) || (ev_cmd == lobm_pkg::CMD_ADD_MARKET);
  assign limited = (ev_cmd == lobm_pkg::CMD_ADD_LIMIT);
  assign is_tgt  = (ev_cmd == lobm_pkg::CMD_CANCEL) || (ev_cmd == lobm_pkg::CMD_MODIFY) ||
                   (ev_cmd == lobm_pkg::CMD_REDUCE);
  assign out_free = !out_vld || rsp.ready;
  assign fill  = (rem < best_e.quantity) ? rem : best_e.quantity;
  assign cont  = best_e.quantity < rem;
  assign t_idx = t0_found ? t0_idx : t1_idx;
  assign t_e   = t0_found ? t0_e : t1_e;

  assign sts.scan_done   = rd_pend && (rd_idx == LAST_IDX);
  assign sts.best_found  = best_found;
  assign sts.free_found  = free_found;
  assign sts.tgt_found   = t0_found || t1_found;
  assign sts.pend_vld    = pend_vld;
  assign sts.out_free    = out_free;
  assign sts.cont        = cont;
  assign sts.scan_needed = (is_add && (ev_qty != 32'd0)) || is_tgt;
  assign sts.is_add      = is_add;
  assign sts.limited     = limited;
  assign sts.rem_zero    = (rem == 32'd0);

  // scan compare on the word read last cycle
  always_comb begin
    e = rd_data;
    v = slot_valid[rd_idx];
    hit_best = v && (e.symbol == ev_sym) && (e.side != ev_side) &&
               (!limited || (ev_side ? (e.price >= ev_price) : (e.price <= ev_price)));
    if (!best_found) better = 1'b1;
    else if (e.price == best_e.price) better = e.arrival < best_e.arrival;
    else better = ev_side ? (e.price > best_e.price) : (e.price < best_e.price);
    hit_tgt = v && (e.symbol == ev_sym) && (e.ord_ref == ev_id);
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wdata = best_e;
    unique case (dcmd.op)
      lobm_pkg::OP_FILL: begin
        we = 1'b1;
        wdata.quantity = best_e.quantity - fill;
      end
      lobm_pkg::OP_INSERT: begin
        we    = 1'b1;
        waddr = free_idx;
        wdata = '{symbol: ev_sym, side: ev_side, price: ev_price, quantity: rem,
                  ord_ref: ev_id, arrival: arrival_counter};
      end
      lobm_pkg::OP_TARGET: begin
        waddr = t_idx;
        wdata = t_e;
        if (ev_cmd == lobm_pkg::CMD_MODIFY) begin
          we             = 1'b1;
          wdata.quantity = ev_qty;
          wdata.price    = ev_price;
          wdata.arrival  = arrival_counter;
        end else if (ev_cmd == lobm_pkg::CMD_REDUCE) begin
          we             = ev_qty < t_e.quantity;
          wdata.quantity = ev_qty;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[scan_idx];
  end

  // event word and match bookkeeping
  always_ff @(posedge clk) begin
    if (dcmd.op == lobm_pkg::OP_LOAD) begin
      ev_cmd   <= req.cmd;
      ev_sym   <= req.symbol_code;
      ev_id    <= req.ord_ref;
      ev_side  <= req.side;
      ev_price <= req.price;
      ev_qty   <= req.quantity;
      rem      <= req.quantity;
      ev_ts    <= req.timestamp;
    end
    if (dcmd.op == lobm_pkg::OP_FILL) begin
      rem        <= rem - fill;
      pend_rid   <= best_e.ord_ref;
      pend_price <= best_e.price;
      pend_fill  <= fill;
    end
    if (rd_pend) begin
      if (is_add && hit_best && better) begin
        best_idx <= rd_idx;
        best_e   <= e;
      end
      if (hit_tgt && !e.side && !t0_found) begin
        t0_idx <= rd_idx;
        t0_e   <= e;
      end
      if (hit_tgt && e.side && !t1_found) begin
        t1_idx <= rd_idx;
        t1_e   <= e;
      end
      if (!v && !free_found) free_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run   <= 1'b0;
      rd_pend    <= 1'b0;
      scan_idx   <= '0;
      rd_idx     <= '0;
      best_found <= 1'b0;
      t0_found   <= 1'b0;
      t1_found   <= 1'b0;
      free_found <= 1'b0;
    end else begin
      rd_pend <= scan_run;
      rd_idx  <= scan_idx;
      if (dcmd.op == lobm_pkg::OP_SCAN) begin
        scan_run   <= 1'b1;
        scan_idx   <= '0;
        best_found <= 1'b0;
        t0_found   <= 1'b0;
        t1_found   <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (scan_run) begin
          scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
          if (scan_idx == LAST_IDX) scan_run <= 1'b0;
        end
        if (rd_pend) begin
          if (is_add && hit_best) best_found <= 1'b1;
          if (hit_tgt && !e.side) t0_found <= 1'b1;
          if (hit_tgt && e.side) t1_found <= 1'b1;
          if (!v) free_found <= 1'b1;
        end
      end
    end
  end

  // valid bits and arrival counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      arrival_counter <= '0;
    end else begin
      unique case (dcmd.op)
        lobm_pkg::OP_FILL: begin
          if (best_e.quantity <= rem) slot_valid[best_idx] <= 1'b0;
        end
        lobm_pkg::OP_INSERT: begin
          slot_valid[free_idx] <= 1'b1;
          arrival_counter      <= arrival_counter + 32'd1;
        end
        lobm_pkg::OP_TARGET: begin
          if (ev_cmd == lobm_pkg::CMD_CANCEL) slot_valid[t_idx] <= 1'b0;
          else if (ev_cmd == lobm_pkg::CMD_MODIFY) arrival_counter <= arrival_counter + 32'd1;
          else if (ev_qty >= t_e.quantity) slot_valid[t_idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result register; a trade is held back until it is known whether it ends the event
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      if ((dcmd.op == lobm_pkg::OP_FILL && pend_vld) || dcmd.op == lobm_pkg::OP_FINAL) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      if (dcmd.op == lobm_pkg::OP_FILL) begin
        pend_vld <= 1'b1;
      end else if (dcmd.op == lobm_pkg::OP_FINAL) begin
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((dcmd.op == lobm_pkg::OP_FILL && pend_vld) || dcmd.op == lobm_pkg::OP_FINAL) begin
      if (pend_vld) begin
        o_trade <= 1'b1;
        o_time  <= ev_ts;
        o_rid   <= pend_rid;
        o_aid   <= ev_id;
        o_sym   <= ev_sym;
        o_price <= pend_price;
        o_qty   <= pend_fill;
        o_side  <= ev_side;
      end else begin
        o_trade <= 1'b0;
        o_time  <= '0;
        o_rid   <= '0;
        o_aid   <= '0;
        o_sym   <= '0;
        o_price <= '0;
        o_qty   <= '0;
        o_side  <= 1'b0;
      end
      o_last   <= (dcmd.op == lobm_pkg::OP_FINAL);
      o_status <= (dcmd.op == lobm_pkg::OP_FINAL) ? dcmd.status : lobm_pkg::ST_DONE;
    end
  end

  assign req.ready          = 1'b0 | (dcmd.op == lobm_pkg::OP_LOAD);
  assign rsp.valid          = out_vld;
  assign rsp.has_trade      = o_trade;
  assign rsp.trade_time     = o_time;
  assign rsp.resting_ref    = o_rid;
  assign rsp.taker_ref      = o_aid;
  assign rsp.trade_symbol   = o_sym;
  assign rsp.trade_price    = o_price;
  assign rsp.trade_quantity = o_qty;
  assign rsp.taker_side     = o_side;
  assign rsp.status         = o_status;
  assign rsp.last           = o_last;

`ifndef SYNTH
  a_fill_idle_scan: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == lobm_pkg::OP_FILL) |-> (!scan_run && !rd_pend && best_found))
    else $error("fill issued during a scan or without a best order");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ((dcmd.op == lobm_pkg::OP_FILL && pend_vld) || dcmd.op == lobm_pkg::OP_FINAL) |-> out_free)
    else $error("result register overwritten");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == lobm_pkg::OP_FINAL) |=> (!pend_vld && out_vld && rsp.last))
    else $error("final word not shown or trade left pending");
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == lobm_pkg::OP_INSERT) |-> (free_found && !slot_valid[free_idx]))
    else $error("insert into an occupied slot");
`endif

endmodule

@@ sv/limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matching over one shared table of resting orders.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event word (add limit, add market, cancel, modify,
//   reduce). rsp returns one word per trade, or a single status word for an
//   event with no trade; last marks the final word of each event.
//   Events are taken one at a time: req.ready rises only while the block is
//   idle and an event is offered. A scan pass reads every slot through the
//   single read port. Each trade that empties its resting order while the
//   event still has quantity left adds a rescan of the table.
//   Reset clears every slot valid bit and the arrival counter; the block is
//   ready right after reset.
//   When rsp stalls the result word holds in its register and the matcher
//   waits before the next trade or final word, so nothing is lost.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
  input logic        clk,
  input logic        rst,
  lobm_req_if.sink   req,
  lobm_rsp_if.source rsp
);

  lobm_pkg::dp_cmd_t dcmd;
  lobm_pkg::dp_sts_t sts;
  logic ctrl_ready;

  lobm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctrl_ready),
    .sts       (sts),
    .dcmd      (dcmd)
  );

  lobm_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .dcmd (dcmd),
    .sts  (sts)
  );

`ifndef SYNTH
  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    (req.ready == (ctrl_ready && req.valid)))
    else $error("ready and load disagree");
`endif

endmodule

@@ dv/lobm_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_tb_pkg
// Event and result word types used by the matcher testbench.
// ----------------------------------------------------------------------------
package lobm_tb_pkg;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] symbol_code;
    logic [31:0] ord_ref;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [62:0] timestamp;
  } book_event_t;

  typedef struct packed {
    logic        has_trade;
    logic [62:0] trade_time;
    logic [31:0] resting_ref;
    logic [31:0] taker_ref;
    logic [15:0] trade_symbol;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        taker_side;
    logic [1:0]  status;
    logic        last;
  } fill_word_t;

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Matcher check against a shadow order book.
// Events are queued by a stimulus process, sent by a clocked driver with
// random gaps, and every result word is compared with the word predicted by
// a shadow copy of the resting-order table, in order.
// ----------------------------------------------------------------------------
module testbench;
  import lobm_pkg::*;
  import lobm_tb_pkg::*;

  localparam int NSLOT = MAX_ORDERS_DEF;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lobm_req_if req ();
  lobm_rsp_if rsp ();

  limit_order_book_matcher dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow book
  bit          sh_valid [NSLOT];
  logic [15:0] sh_symbol [NSLOT];
  logic        sh_side [NSLOT];
  logic [31:0] sh_price [NSLOT];
  logic [31:0] sh_qty [NSLOT];
  logic [31:0] sh_id [NSLOT];
  logic [31:0] sh_arrival [NSLOT];
  logic [31:0] sh_arrival_ctr;

  book_event_t pending_events[$];
  fill_word_t  expected_fills[$];

  int errors = 0;
  int n_sent = 0;
  int n_words = 0;
  int n_trades = 0;
  int n_full = 0;
  int n_missing = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  int rx_gap = 0;

  function automatic int best_resting(logic [15:0] sym, logic aside, bit limited,
                                      logic [31:0] lim);
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_valid[i] || sh_symbol[i] != sym || sh_side[i] == aside) continue;
      if (limited && aside == 1'b0 && sh_price[i] > lim) continue;
      if (limited && aside == 1'b1 && sh_price[i] < lim) continue;
      if (b < 0) b = i;
      else if (sh_price[i] == sh_price[b]) begin
        if (sh_arrival[i] < sh_arrival[b]) b = i;
      end else if (aside == 1'b0 ? sh_price[i] < sh_price[b]
                                 : sh_price[i] > sh_price[b]) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic int find_order(logic [15:0] sym, logic [31:0] id);
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < NSLOT; i++)
        if (sh_valid[i] && sh_symbol[i] == sym && sh_side[i] == s && sh_id[i] == id)
          return i;
    return -1;
  endfunction

  // apply one event to the shadow book and queue its result words
  function automatic void match_event(book_event_t e);
    fill_word_t w;
    fill_word_t words[$];
    logic [31:0] remaining;
    logic [31:0] fill;
    logic [1:0] st;
    bit limited;
    int b;
    int f;
    st = ST_DONE;
    if (e.cmd == CMD_ADD_LIMIT || e.cmd == CMD_ADD_MARKET) begin
      remaining = e.quantity;
      limited = (e.cmd == CMD_ADD_LIMIT);
      while (remaining > 0 && words.size() < NSLOT) begin
        b = best_resting(e.symbol_code, e.side, limited, e.price);
        if (b < 0) break;
        fill = remaining < sh_qty[b] ? remaining : sh_qty[b];
        sh_qty[b] -= fill;
        remaining -= fill;
        w = '{1'b1, e.timestamp, sh_id[b], e.ord_ref, e.symbol_code, sh_price[b],
              fill, e.side, ST_DONE, 1'b0};
        words = {words, w};
        if (sh_qty[b] == 0) sh_valid[b] = 0;
        else break;
      end
      if (limited && remaining > 0) begin
        f = -1;
        for (int i = 0; i < NSLOT; i++)
          if (!sh_valid[i]) begin
            f = i;
            break;
          end
        if (f < 0) st = ST_FULL;
        else begin
          sh_valid[f] = 1;
          sh_symbol[f] = e.symbol_code;
          sh_side[f] = e.side;
          sh_price[f] = e.price;
          sh_qty[f] = remaining;
          sh_id[f] = e.ord_ref;
          sh_arrival[f] = sh_arrival_ctr;
          sh_arrival_ctr++;
        end
      end
    end else if (e.cmd == CMD_CANCEL || e.cmd == CMD_MODIFY || e.cmd == CMD_REDUCE) begin
      b = find_order(e.symbol_code, e.ord_ref);
      if (b < 0) st = ST_NOT_FOUND;
      else if (e.cmd == CMD_CANCEL) sh_valid[b] = 0;
      else if (e.cmd == CMD_MODIFY) begin
        sh_qty[b] = e.quantity;
        sh_price[b] = e.price;
        sh_arrival[b] = sh_arrival_ctr;
        sh_arrival_ctr++;
      end else if (e.quantity >= sh_qty[b]) sh_valid[b] = 0;
      else sh_qty[b] = e.quantity;
    end
    if (words.size() == 0) begin
      w = '0;
      words = {words, w};
    end
    words[$].status = st;
    words[$].last = 1'b1;
    foreach (words[i]) expected_fills = {expected_fills, words[i]};
  endfunction

  function automatic book_event_t mk(logic [2:0] c, logic [15:0] s, logic [31:0] id,
                                     logic sd, logic [31:0] p, logic [31:0] q);
    book_event_t e;
    e.cmd = c;
    e.symbol_code = s;
    e.ord_ref = id;
    e.side = sd;
    e.price = p;
    e.quantity = q;
    e.timestamp = 63'({$urandom, $urandom});
    return e;
  endfunction

  task automatic enqueue(book_event_t e);
    pending_events = {pending_events, e};
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        match_event(pending_events.pop_front());
        n_sent++;
      end
      if (req.valid && !req.ready) begin
        // hold the offered word
      end else if (gap > 0) begin
        gap <= gap - 1;
        req.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        book_event_t e;
        e = pending_events[0];
        req.valid <= 1'b1;
        req.cmd <= e.cmd;
        req.symbol_code <= e.symbol_code;
        req.ord_ref <= e.ord_ref;
        req.side <= e.side;
        req.price <= e.price;
        req.quantity <= e.quantity;
        req.timestamp <= e.timestamp;
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 150)
                                           : $urandom_range(0, 2);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    fill_word_t a;
    fill_word_t x;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        a = '{rsp.has_trade, rsp.trade_time, rsp.resting_ref,
              rsp.taker_ref, rsp.trade_symbol, rsp.trade_price,
              rsp.trade_quantity, rsp.taker_side, rsp.status, rsp.last};
        n_words++;
        if (a.has_trade) n_trades++;
        if (a.status == ST_FULL) n_full++;
        if (a.status == ST_NOT_FOUND) n_missing++;
        if (expected_fills.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, a);
          errors++;
        end else begin
          x = expected_fills.pop_front();
          if (a !== x) begin
            $display("%0t: result mismatch", $time);
            $display("  expected %p", x);
            $display("  actual   %p", a);
            errors++;
          end
        end
      end
      if (hold_off) begin
        rsp.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        rx_gap <= $urandom_range(10, 80);
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= ($urandom_range(0, 1) == 1);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    int cnt;
    wait (n_sent > 40);
    @(posedge clk);
    hold_off = 1;
    cnt = 0;
    while (cnt < 600) begin
      @(posedge clk);
      cnt++;
    end
    hold_off = 0;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_random(int n);
    logic [15:0] sym;
    logic [31:0] id;
    int r;
    for (int k = 0; k < n; k++) begin
      sym = 16'hA000 + 16'($urandom_range(0, 2));
      id = $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      if (r < 45)
        enqueue(mk(CMD_ADD_LIMIT, sym, id, 1'($urandom_range(0, 1)),
                   100 + $urandom_range(0, 8), $urandom_range(0, 30)));
      else if (r < 55)
        enqueue(mk(CMD_ADD_MARKET, sym, id, 1'($urandom_range(0, 1)),
                   $urandom, $urandom_range(0, 60)));
      else if (r < 67)
        enqueue(mk(CMD_CANCEL, sym, id, 1'($urandom_range(0, 1)),
                   $urandom, $urandom));
      else if (r < 79)
        enqueue(mk(CMD_MODIFY, sym, id, 1'($urandom_range(0, 1)),
                   100 + $urandom_range(0, 8), $urandom_range(0, 30)));
      else if (r < 91)
        enqueue(mk(CMD_REDUCE, sym, id, 1'($urandom_range(0, 1)),
                   $urandom, $urandom_range(0, 30)));
      else if (r < 94)
        enqueue(mk(3'($urandom_range(5, 7)), sym, id, 1'($urandom_range(0, 1)),
                   $urandom, $urandom));
      else
        // wide noise over every field bit
        enqueue(mk(3'($urandom_range(0, 4)), 16'($urandom), $urandom,
                   1'($urandom_range(0, 1)), $urandom, $urandom));
    end
  endtask

  initial begin
    int wait_cnt;
    req.valid = 1'b0;
    req.cmd = '0;
    req.symbol_code = '0;
    req.ord_ref = '0;
    req.side = 1'b0;
    req.price = '0;
    req.quantity = '0;
    req.timestamp = '0;
    rsp.ready = 1'b0;
    foreach (sh_valid[i]) sh_valid[i] = 0;
    sh_arrival_ctr = '0;

    // directed: extremes, every command, and the named corner cases
    enqueue(mk(CMD_ADD_LIMIT, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF));
    enqueue(mk(CMD_ADD_MARKET, 16'hFFFF, 32'h0, 1'b0, 32'h0, 32'h5));
    enqueue(mk(CMD_ADD_LIMIT, 16'h0, 32'h0, 1'b0, 32'h0, 32'h0));
    enqueue(mk(CMD_ADD_LIMIT, 16'h1, 32'h10, 1'b1, 32'd50, 32'd10));
    enqueue(mk(CMD_ADD_LIMIT, 16'h1, 32'h11, 1'b1, 32'd50, 32'd10));
    enqueue(mk(CMD_ADD_LIMIT, 16'h1, 32'h12, 1'b1, 32'd49, 32'd10));
    enqueue(mk(CMD_ADD_LIMIT, 16'h1, 32'h11, 1'b0, 32'd10, 32'd4));
    enqueue(mk(CMD_MODIFY, 16'h1, 32'h10, 1'b0, 32'd50, 32'd0));
    enqueue(mk(CMD_ADD_LIMIT, 16'h1, 32'h20, 1'b0, 32'd50, 32'd25));
    enqueue(mk(CMD_REDUCE, 16'h1, 32'h11, 1'b0, 32'd0, 32'd2));
    enqueue(mk(CMD_REDUCE, 16'h1, 32'h11, 1'b0, 32'd0, 32'd9));
    enqueue(mk(CMD_CANCEL, 16'h1, 32'h11, 1'b0, 32'd0, 32'd0));
    enqueue(mk(CMD_CANCEL, 16'h2, 32'h99, 1'b0, 32'd0, 32'd0));
    enqueue(mk(CMD_MODIFY, 16'h2, 32'h99, 1'b0, 32'd0, 32'd0));
    enqueue(mk(3'd7, 16'h2, 32'h99, 1'b1, 32'd0, 32'd0));
    enqueue(mk(3'd5, 16'h2, 32'h99, 1'b1, 32'd0, 32'd0));
    enqueue(mk(CMD_ADD_MARKET, 16'h1, 32'h21, 1'b1, 32'd0, 32'hFFFFFFFF));
    // fill the table, then overflow it
    for (int i = 0; i < NSLOT + 2; i++)
      enqueue(mk(CMD_ADD_LIMIT, 16'h7, 32'(i), 1'b0, 32'd5, 32'd1));
    // one sell sweeps many resting buys in one event
    enqueue(mk(CMD_ADD_LIMIT, 16'h7, 32'h77, 1'b1, 32'd5, 32'd40));
    enqueue(mk(CMD_ADD_MARKET, 16'h7, 32'h78, 1'b1, 32'd0, 32'd100));

    add_random(240);

    wait (pending_events.size() == 0 && !req.valid);
    wait_cnt = 0;
    while (expected_fills.size() != 0 && wait_cnt < WATCHDOG) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d events, checked %0d result words: %0d trades,", n_sent,
             n_words, n_trades);
    $display("  %0d dropped on full table, %0d targets not found", n_full, n_missing);
    if (errors == 0 && expected_fills.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
